/* rtl/lae_pkg.sv */
// ----------------------------------------------------------------------------
// lae_pkg
// Shared types, widths and codes of the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package lae_pkg;

	localparam int LEVEL_BITS     = 16;
	localparam int DURATION_BITS  = 24;
	localparam int STEP_BITS      = 12;
	localparam int STAGE_BITS     = 3;
	localparam int HOLD_BITS      = DURATION_BITS + 1;
	localparam int PROD_BITS      = STEP_BITS + LEVEL_BITS;
	localparam int SUM_BITS       = PROD_BITS + 1;
	localparam int DIV_CNT_BITS   = $clog2(PROD_BITS + 1);
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = (DURATION_BITS > LEVEL_BITS) ? DURATION_BITS : LEVEL_BITS;

	localparam logic [LEVEL_BITS-1:0] PEAK_LEVEL_RST    = LEVEL_BITS'(16384);
	localparam logic [LEVEL_BITS-1:0] SUSTAIN_LEVEL_RST = LEVEL_BITS'(8192);

	// envelope phase codes, as seen on the stage field
	typedef enum logic [STAGE_BITS-1:0] {
		PH_ATTACK   = 3'd0,
		PH_DECAY    = 3'd1,
		PH_SUSTAIN  = 3'd2,
		PH_RELEASE  = 3'd3,
		PH_FINISHED = 3'd4
	} phase_t;

	// configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_PEAK_LEVEL       = 3'd0,
		CFG_SUSTAIN_LEVEL    = 3'd1,
		CFG_RELEASE_LEVEL    = 3'd2,
		CFG_ATTACK_DURATION  = 3'd3,
		CFG_DECAY_DURATION   = 3'd4,
		CFG_HOLD_DURATION    = 3'd5,
		CFG_RELEASE_DURATION = 3'd6
	} cfg_reg_t;

	// sequencer states
	typedef enum logic [2:0] {
		SEQ_IDLE    = 3'd0,
		SEQ_SETUP   = 3'd1,
		SEQ_DIVIDE  = 3'd2,
		SEQ_UPDATE  = 3'd3,
		SEQ_DELIVER = 3'd4
	} seq_state_t;

	typedef struct packed {
		logic [STEP_BITS-1:0] step_time;
		logic                 key_down;
		logic                 pedal_down;
	} in_item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] level_out;
		logic [STAGE_BITS-1:0] stage;
	} out_item_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0]    peak_level;
		logic [LEVEL_BITS-1:0]    sustain_level;
		logic [LEVEL_BITS-1:0]    release_level;
		logic [DURATION_BITS-1:0] attack_duration;
		logic [DURATION_BITS-1:0] decay_duration;
		logic [DURATION_BITS-1:0] hold_duration;
		logic [DURATION_BITS-1:0] release_duration;
	} cfg_t;

	typedef struct packed {
		logic                     start;
		logic [PROD_BITS-1:0]     dividend;
		logic [DURATION_BITS-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic                 busy;
		logic [PROD_BITS-1:0] quotient;
	} div_rsp_t;

endpackage

`default_nettype wire

/* rtl/lae_cfg.sv */
// ----------------------------------------------------------------------------
// lae_cfg
// Configuration register file: levels and durations, write only.
// ----------------------------------------------------------------------------
`default_nettype none

module lae_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [lae_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [lae_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
	output lae_pkg::cfg_t                             cfg
);
	import lae_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.peak_level       <= PEAK_LEVEL_RST;
			cfg_q.sustain_level    <= SUSTAIN_LEVEL_RST;
			cfg_q.release_level    <= '0;
			cfg_q.attack_duration  <= '0;
			cfg_q.decay_duration   <= '0;
			cfg_q.hold_duration    <= '0;
			cfg_q.release_duration <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_PEAK_LEVEL:       cfg_q.peak_level       <= cfg_wr_data[LEVEL_BITS-1:0];
				CFG_SUSTAIN_LEVEL:    cfg_q.sustain_level    <= cfg_wr_data[LEVEL_BITS-1:0];
				CFG_RELEASE_LEVEL:    cfg_q.release_level    <= cfg_wr_data[LEVEL_BITS-1:0];
				CFG_ATTACK_DURATION:  cfg_q.attack_duration  <= cfg_wr_data[DURATION_BITS-1:0];
				CFG_DECAY_DURATION:   cfg_q.decay_duration   <= cfg_wr_data[DURATION_BITS-1:0];
				CFG_HOLD_DURATION:    cfg_q.hold_duration    <= cfg_wr_data[DURATION_BITS-1:0];
				CFG_RELEASE_DURATION: cfg_q.release_duration <= cfg_wr_data[DURATION_BITS-1:0];
				default: begin
					// unused index, write dropped
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

/* rtl/lae_div.sv */
// ----------------------------------------------------------------------------
// lae_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lae_div (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  lae_pkg::div_req_t  req,
	output lae_pkg::div_rsp_t  rsp
);
	import lae_pkg::*;

	logic                     busy_q;
	logic                     done_q;
	logic [DIV_CNT_BITS-1:0]  cnt_q;
	logic [PROD_BITS-1:0]     dvd_q;   // dividend shifts out, quotient shifts in
	logic [DURATION_BITS-1:0] rem_q;
	logic [DURATION_BITS-1:0] dvs_q;

	logic [DURATION_BITS:0]   trial;
	logic                     fits;

	assign trial = {rem_q, dvd_q[PROD_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= DIV_CNT_BITS'(PROD_BITS);
		end else begin
			done_q <= busy_q && (cnt_q == DIV_CNT_BITS'(1));
			if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_BITS'(1);
				if (cnt_q == DIV_CNT_BITS'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[PROD_BITS-2:0], fits};
			if (fits) begin
				rem_q <= DURATION_BITS'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DURATION_BITS-1:0];
			end
		end
	end

	assign rsp = '{done: done_q, busy: busy_q, quotient: dvd_q};

endmodule

`default_nettype wire

/* rtl/linear_adsr_envelope.sv */
// ----------------------------------------------------------------------------
// linear_adsr_envelope
// Linear attack/decay/sustain/release envelope with one serial divider.
// ----------------------------------------------------------------------------
// Each input transfer advances the envelope by step_time units and yields one
// output transfer with the new volume and phase. An item passes from its input
// transfer to the output register in these steps: a setup state that applies a
// key release and forms step_time * span on the multiplier, the serial divider
// (one bit per cycle over the 28-bit product), collection of the quotient once
// the divider signals done, an update state and a deliver state that loads the
// output register. The next input transfer is taken only once the sequencer is
// back in idle, so an item cannot enter before the last one is through. Items
// that need no slope (sustain, finished, zero durations or zero peak in attack,
// pedal held in release) skip the divider. in_stall stays high from the input
// transfer until the result is in the output register; a result still stalled
// in the output register holds the load cycle until it leaves, and the output
// register lets the next item enter while that result still waits. Configuration
// writes are meant for idle periods. Only reset retriggers the envelope.
// ----------------------------------------------------------------------------
`default_nettype none

module linear_adsr_envelope (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// configuration write port
	input  wire logic                                 cfg_wr_en,
	input  wire logic [lae_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  wire logic [lae_pkg::CFG_DATA_BITS-1:0]    cfg_wr_data,
	// input channel
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  lae_pkg::in_item_t                         in_data,
	// output channel
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output lae_pkg::out_item_t                        out_data
);
	import lae_pkg::*;

	cfg_t       cfg;
	div_req_t   div_req;
	div_rsp_t   div_rsp;

	seq_state_t state_q, state_d;

	// item registers, loaded on the input transfer
	logic [STEP_BITS-1:0]  step_q;
	logic                  key_q;
	logic                  pedal_q;

	// envelope state
	phase_t                phase_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [LEVEL_BITS-1:0] rsl_q;     // volume at release start
	logic [HOLD_BITS-1:0]  hold_q;    // time spent in sustain

	// output register
	logic                  out_valid_q;
	out_item_t             out_data_q;

	logic                  in_xfer;
	logic                  out_xfer;

	// setup cycle
	logic                  rel_entry;
	phase_t                phase_eff;
	logic [LEVEL_BITS-1:0] rsl_eff;
	logic [LEVEL_BITS-1:0] span;
	logic                  need_div;

	// update cycle
	logic [PROD_BITS-1:0]  quot;
	logic [SUM_BITS-1:0]   att_sum;
	logic [LEVEL_BITS-1:0] ramp_down;
	logic [HOLD_BITS-1:0]  hold_sum;
	phase_t                phase_nx;
	logic [LEVEL_BITS-1:0] level_nx;
	logic [LEVEL_BITS-1:0] rsl_nx;
	logic [HOLD_BITS-1:0]  hold_nx;

	lae_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wr_data(cfg_wr_data),
		.cfg        (cfg)
	);

	lae_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign in_stall  = (state_q != SEQ_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_xfer  = out_valid_q && !out_stall;
	assign out_data  = out_data_q;

	// key up with pedal up forces release before the phase update
	always_comb begin
		rel_entry = !key_q && !pedal_q &&
			(phase_q == PH_ATTACK || phase_q == PH_DECAY || phase_q == PH_SUSTAIN);
		phase_eff = rel_entry ? PH_RELEASE : phase_q;
		rsl_eff   = rel_entry ? level_q : rsl_q;
	end

	// slope operands for the phase in force, divider kicked off from setup
	always_comb begin
		span            = '0;
		need_div        = 1'b0;
		div_req.divisor = '0;
		unique case (phase_eff)
			PH_ATTACK: begin
				span            = cfg.peak_level;
				div_req.divisor = cfg.attack_duration;
				need_div        = (cfg.attack_duration != '0) && (cfg.peak_level != '0);
			end
			PH_DECAY: begin
				span            = (cfg.peak_level > cfg.sustain_level) ?
					cfg.peak_level - cfg.sustain_level : '0;
				div_req.divisor = cfg.decay_duration;
				need_div        = (cfg.decay_duration != '0);
			end
			PH_RELEASE: begin
				span            = (rsl_eff > cfg.release_level) ?
					rsl_eff - cfg.release_level : '0;
				div_req.divisor = cfg.release_duration;
				need_div        = (cfg.release_duration != '0) && !pedal_q;
			end
			default: begin
				// sustain and finished move no volume by slope
			end
		endcase
		div_req.dividend = PROD_BITS'(step_q) * PROD_BITS'(span);
		div_req.start    = (state_q == SEQ_SETUP) && need_div;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			SEQ_IDLE: begin
				if (in_xfer) begin
					state_d = SEQ_SETUP;
				end
			end
			SEQ_SETUP: begin
				state_d = need_div ? SEQ_DIVIDE : SEQ_UPDATE;
			end
			SEQ_DIVIDE: begin
				if (div_rsp.done) begin
					state_d = SEQ_UPDATE;
				end
			end
			SEQ_UPDATE: begin
				state_d = SEQ_DELIVER;
			end
			SEQ_DELIVER: begin
				if (!out_valid_q || !out_stall) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	// phase update; the quotient is only read where a division ran
	always_comb begin
		quot      = div_rsp.quotient;
		att_sum   = SUM_BITS'(level_q) + SUM_BITS'(quot);
		ramp_down = (quot >= PROD_BITS'(level_q)) ? '0 : level_q - quot[LEVEL_BITS-1:0];
		hold_sum  = hold_q + HOLD_BITS'(step_q);
		phase_nx  = phase_q;
		level_nx  = level_q;
		rsl_nx    = rsl_q;
		hold_nx   = hold_q;
		unique case (phase_q)
			PH_ATTACK: begin
				// zero duration or zero peak jumps to the peak
				if ((cfg.attack_duration == '0) || (cfg.peak_level == '0) ||
					(att_sum >= SUM_BITS'(cfg.peak_level))) begin
					level_nx = cfg.peak_level;
					rsl_nx   = cfg.peak_level;
					phase_nx = PH_DECAY;
				end else begin
					level_nx = att_sum[LEVEL_BITS-1:0];
				end
			end
			PH_DECAY: begin
				if ((cfg.decay_duration == '0) || (ramp_down <= cfg.sustain_level)) begin
					level_nx = cfg.sustain_level;
					rsl_nx   = cfg.sustain_level;
					hold_nx  = '0;
					phase_nx = PH_SUSTAIN;
				end else begin
					level_nx = ramp_down;
				end
			end
			PH_SUSTAIN: begin
				// zero hold time waits for the key
				if (cfg.hold_duration != '0) begin
					hold_nx = hold_sum;
					if (hold_sum >= HOLD_BITS'(cfg.hold_duration)) begin
						rsl_nx   = level_q;
						phase_nx = PH_RELEASE;
					end
				end
			end
			PH_RELEASE: begin
				// pedal freezes the ramp, but a level already down still finishes
				if (!pedal_q && (cfg.release_duration == '0)) begin
					level_nx = cfg.release_level;
				end else if (!pedal_q) begin
					level_nx = ramp_down;
				end
				if ((!pedal_q && (cfg.release_duration == '0)) ||
					((!pedal_q ? ramp_down : level_q) <= cfg.release_level)) begin
					level_nx = cfg.release_level;
					rsl_nx   = cfg.release_level;
					phase_nx = PH_FINISHED;
				end
			end
			default: begin
				// finished holds
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			step_q  <= in_data.step_time;
			key_q   <= in_data.key_down;
			pedal_q <= in_data.pedal_down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ATTACK;
			level_q <= '0;
			rsl_q   <= '0;
			hold_q  <= '0;
		end else if (state_q == SEQ_SETUP) begin
			phase_q <= phase_eff;
			rsl_q   <= rsl_eff;
		end else if (state_q == SEQ_UPDATE) begin
			phase_q <= phase_nx;
			level_q <= level_nx;
			rsl_q   <= rsl_nx;
			hold_q  <= hold_nx;
		end
	end

	// output register, loaded when it is empty or its previous result leaves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == SEQ_DELIVER && (!out_valid_q || !out_stall)) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == SEQ_DELIVER && (!out_valid_q || !out_stall)) begin
			out_data_q.level_out <= level_q;
			out_data_q.stage     <= phase_q;
		end
	end

	// an input transfer always starts the setup cycle
	a_xfer_setup: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> (state_q == SEQ_SETUP))
		else $error("input transfer did not start setup");

	// a new result appears only from the deliver state
	a_out_from_deliver: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == SEQ_DELIVER))
		else $error("result loaded outside deliver");

	// the divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == SEQ_DIVIDE))
		else $error("divider done outside divide state");

	// the phase moves only in setup or update
	a_phase_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SEQ_IDLE || state_q == SEQ_DIVIDE || state_q == SEQ_DELIVER)
		|=> $stable(phase_q))
		else $error("phase changed outside setup or update");

endmodule

`default_nettype wire
